### src/mcbr_pkg.sv
// mcbr_pkg: shared types and constants of the memory card byte responder
// depends on nothing; used by the front end, the back end and the top level

package mcbr_pkg;

  // sector geometry, fixed by the card format
  localparam int SECTOR_BYTES = 128;
  localparam int BUF_AW       = $clog2(SECTOR_BYTES);
  localparam int CNT_W        = BUF_AW + 1;

  // depth of the queues between the parts
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // request codes on req_type
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // byte positions within a transaction
  localparam logic [7:0] POS_FIRST   = 8'd2;
  localparam logic [7:0] POS_ID2     = 8'd3;
  localparam logic [7:0] POS_SECT_HI = 8'd4;
  localparam logic [7:0] POS_SECT_LO = 8'd5;
  localparam logic [7:0] POS_RD_ACK1 = 8'd6;
  localparam logic [7:0] POS_RD_ACK2 = 8'd7;
  localparam logic [7:0] POS_RD_HI   = 8'd8;
  localparam logic [7:0] POS_RD_LO   = 8'd9;
  localparam logic [7:0] POS_RD_DATA = 8'd10;
  localparam logic [7:0] POS_RD_CHK  = 8'd138;
  localparam logic [7:0] POS_RD_LAST = 8'd139;
  localparam logic [7:0] POS_WR_DATA = 8'd6;
  localparam logic [7:0] POS_WR_CHK  = 8'd134;
  localparam logic [7:0] POS_WR_ACK1 = 8'd135;
  localparam logic [7:0] POS_WR_ACK2 = 8'd136;
  localparam logic [7:0] POS_WR_LAST = 8'd137;

  // response bytes
  localparam logic [7:0] RSP_NONE      = 8'h00;
  localparam logic [7:0] RSP_ID1       = 8'h5A;
  localparam logic [7:0] RSP_ID2       = 8'h5D;
  localparam logic [7:0] RSP_ACK1      = 8'h5C;
  localparam logic [7:0] RSP_GOOD      = 8'h47;
  localparam logic [7:0] RSP_BAD_CHECK = 8'h4E;
  localparam logic [7:0] RSP_BAD       = 8'hFF;

  // work handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_IMM,
    OP_START,
    OP_WR_BYTE,
    OP_RD_LOAD,
    OP_RD_BYTE,
    OP_RD_CHECK,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        ack;
    logic [6:0]  index;
    logic        seed;
    logic [7:0]  seed_value;
    logic [15:0] sector;
    logic        sector_valid;
    logic [7:0]  expected;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       ack;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_LOAD,
    ST_COMMIT
  } back_state_t;

endpackage

### src/mcbr_ram.sv
// mcbr_ram: generic single write port, single read port memory
// registered read data; no dependencies

module mcbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mcbr_fifo.sv
// mcbr_fifo: small register queue with full and empty flags
// no dependencies; DEPTH must be at least 2

module mcbr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### src/mcbr_front.sv
// mcbr_front: accepts host bytes, tracks position and sector, classifies work
// depends on mcbr_pkg

module mcbr_front #(
  parameter int SECTOR_COUNT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type,
  input  logic [7:0]        data_in,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              cmdq_full,
  input  logic              clearing,
  output logic              cmd_push,
  output mcbr_pkg::cmd_t    cmd
);

  logic       card_present;
  logic [7:0] pos;
  logic [7:0] pos_next;
  logic [7:0] sector_high;
  logic [7:0] sector_high_next;
  logic [7:0] sector_low;
  logic [7:0] sector_low_next;
  logic [7:0] expected_check;
  logic [7:0] expected_check_next;
  logic       sector_valid;
  logic       sector_valid_next;
  logic       accept;
  logic       lo_in_range;
  logic [7:0] rd_offset;
  logic [7:0] wr_offset;

  assign full      = cmdq_full || clearing;
  assign accept    = push && !full;
  assign cmd_push  = accept;
  assign cfg_ready = 1'b1;

  assign lo_in_range = ({1'b0, sector_high, data_in} < 17'(SECTOR_COUNT));
  assign rd_offset   = pos - mcbr_pkg::POS_RD_DATA;
  assign wr_offset   = pos - mcbr_pkg::POS_WR_DATA;

  always_comb begin
    pos_next            = pos;
    sector_high_next    = sector_high;
    sector_low_next     = sector_low;
    expected_check_next = expected_check;
    sector_valid_next   = sector_valid;

    cmd              = '0;
    cmd.op           = mcbr_pkg::OP_IMM;
    cmd.data         = mcbr_pkg::RSP_NONE;
    cmd.ack          = 1'b0;
    cmd.seed_value   = sector_high ^ sector_low;
    cmd.sector       = {sector_high, sector_low};
    cmd.sector_valid = sector_valid;
    cmd.expected     = expected_check;

    case (req_type)
      mcbr_pkg::REQ_START: begin
        cmd.op              = mcbr_pkg::OP_START;
        cmd.data            = mcbr_pkg::RSP_BAD;
        cmd.ack             = card_present;
        pos_next            = mcbr_pkg::POS_FIRST;
        sector_high_next    = '0;
        sector_low_next     = '0;
        expected_check_next = '0;
      end
      mcbr_pkg::REQ_READ: begin
        if (!card_present) begin
          cmd.data = mcbr_pkg::RSP_BAD;
        end else if (pos >= mcbr_pkg::POS_FIRST && pos <= mcbr_pkg::POS_RD_LAST) begin
          cmd.ack   = 1'b1;
          cmd.index = rd_offset[6:0];
          pos_next  = pos + 8'd1;
          case (pos)
            mcbr_pkg::POS_FIRST:   cmd.data = mcbr_pkg::RSP_ID1;
            mcbr_pkg::POS_ID2:     cmd.data = mcbr_pkg::RSP_ID2;
            mcbr_pkg::POS_SECT_HI: sector_high_next = data_in;
            mcbr_pkg::POS_SECT_LO: begin
              sector_low_next   = data_in;
              sector_valid_next = lo_in_range;
            end
            mcbr_pkg::POS_RD_ACK1: cmd.data = mcbr_pkg::RSP_ACK1;
            mcbr_pkg::POS_RD_ACK2: cmd.data = mcbr_pkg::RSP_ID2;
            mcbr_pkg::POS_RD_HI:   cmd.data = sector_high;
            mcbr_pkg::POS_RD_LO:   cmd.data = sector_low;
            mcbr_pkg::POS_RD_DATA: cmd.op = mcbr_pkg::OP_RD_LOAD;
            mcbr_pkg::POS_RD_CHK:  cmd.op = mcbr_pkg::OP_RD_CHECK;
            mcbr_pkg::POS_RD_LAST: begin
              cmd.data = mcbr_pkg::RSP_GOOD;
              cmd.ack  = 1'b0;
            end
            default:               cmd.op = mcbr_pkg::OP_RD_BYTE;
          endcase
        end
      end
      mcbr_pkg::REQ_WRITE: begin
        if (pos >= mcbr_pkg::POS_FIRST && pos <= mcbr_pkg::POS_WR_LAST) begin
          cmd.ack   = 1'b1;
          cmd.index = wr_offset[6:0];
          pos_next  = pos + 8'd1;
          case (pos)
            mcbr_pkg::POS_FIRST:   cmd.data = mcbr_pkg::RSP_ID1;
            mcbr_pkg::POS_ID2:     cmd.data = mcbr_pkg::RSP_ID2;
            mcbr_pkg::POS_SECT_HI: sector_high_next = data_in;
            mcbr_pkg::POS_SECT_LO: begin
              sector_low_next   = data_in;
              sector_valid_next = lo_in_range;
            end
            mcbr_pkg::POS_WR_CHK:  expected_check_next = data_in;
            mcbr_pkg::POS_WR_ACK1: cmd.data = mcbr_pkg::RSP_ACK1;
            mcbr_pkg::POS_WR_ACK2: cmd.data = mcbr_pkg::RSP_ID2;
            mcbr_pkg::POS_WR_LAST: begin
              cmd.op  = mcbr_pkg::OP_COMMIT;
              cmd.ack = 1'b0;
            end
            default: begin
              cmd.op   = mcbr_pkg::OP_WR_BYTE;
              cmd.data = data_in;
              cmd.seed = (pos == mcbr_pkg::POS_WR_DATA);
            end
          endcase
        end
      end
      default: begin
        cmd.data = mcbr_pkg::RSP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      card_present   <= 1'b1;
      pos            <= mcbr_pkg::POS_FIRST;
      sector_high    <= '0;
      sector_low     <= '0;
      expected_check <= '0;
      sector_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        card_present <= cfg_data;
      end
      if (accept) begin
        pos            <= pos_next;
        sector_high    <= sector_high_next;
        sector_low     <= sector_low_next;
        expected_check <= expected_check_next;
        sector_valid   <= sector_valid_next;
      end
    end
  end

endmodule

### src/mcbr_back.sv
// mcbr_back: carries out queued work on the sector buffer and the card store
// depends on mcbr_pkg and mcbr_ram

module mcbr_back #(
  parameter int SECTOR_COUNT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  mcbr_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output mcbr_pkg::result_t res,
  output logic              clearing
);

  localparam int BUF_AW      = mcbr_pkg::BUF_AW;
  localparam int CNT_W       = mcbr_pkg::CNT_W;
  localparam int SECT_W      = $clog2(SECTOR_COUNT);
  localparam int STORE_AW    = SECT_W + BUF_AW;
  localparam int STORE_DEPTH = SECTOR_COUNT * mcbr_pkg::SECTOR_BYTES;

  mcbr_pkg::back_state_t state;
  mcbr_pkg::back_state_t state_next;

  logic [CNT_W-1:0]                 cnt;
  logic [CNT_W-1:0]                 cnt_next;
  logic [7:0]                       rc;
  logic [7:0]                       rc_next;
  logic [mcbr_pkg::SECTOR_BYTES-1:0] buf_valid;
  logic [mcbr_pkg::SECTOR_BYTES-1:0] buf_valid_next;
  logic [STORE_AW-1:0]              clear_addr;
  logic [STORE_AW-1:0]              clear_addr_next;
  logic [7:0]                       first_byte;
  logic                             vld_q;

  logic              go;
  logic              check_ok;
  logic              sweep_done;
  logic              clear_done;
  logic [BUF_AW-1:0] cnt_prev;
  logic [7:0]        rd_byte;

  logic              buf_we;
  logic [BUF_AW-1:0] buf_waddr;
  logic [7:0]        buf_wdata;
  logic [BUF_AW-1:0] buf_raddr;
  logic [7:0]        buf_rdata;

  logic                st_we;
  logic [STORE_AW-1:0] st_waddr;
  logic [7:0]          st_wdata;
  logic [STORE_AW-1:0] st_raddr;
  logic [7:0]          st_rdata;

  assign go         = cmd_valid && !res_full;
  assign check_ok   = (cmd.expected == rc);
  assign sweep_done = (cnt == CNT_W'(mcbr_pkg::SECTOR_BYTES));
  assign clear_done = (clear_addr == STORE_AW'(STORE_DEPTH - 1));
  assign cnt_prev   = cnt[BUF_AW-1:0] - BUF_AW'(1);
  assign rd_byte    = vld_q ? buf_rdata : 8'h00;
  assign clearing   = (state == mcbr_pkg::ST_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mcbr_pkg::ST_CLEAR: begin
        if (clear_done) state_next = mcbr_pkg::ST_IDLE;
      end
      mcbr_pkg::ST_IDLE: begin
        if (go) begin
          case (cmd.op)
            mcbr_pkg::OP_RD_BYTE: state_next = mcbr_pkg::ST_RD_WAIT;
            mcbr_pkg::OP_RD_LOAD: begin
              if (cmd.sector_valid) state_next = mcbr_pkg::ST_LOAD;
            end
            mcbr_pkg::OP_COMMIT: begin
              if (cmd.sector_valid && check_ok) state_next = mcbr_pkg::ST_COMMIT;
            end
            default: state_next = mcbr_pkg::ST_IDLE;
          endcase
        end
      end
      mcbr_pkg::ST_RD_WAIT: state_next = mcbr_pkg::ST_IDLE;
      mcbr_pkg::ST_LOAD: begin
        if (sweep_done) state_next = mcbr_pkg::ST_IDLE;
      end
      mcbr_pkg::ST_COMMIT: begin
        if (sweep_done) state_next = mcbr_pkg::ST_IDLE;
      end
      default: state_next = mcbr_pkg::ST_IDLE;
    endcase
  end

  // datapath register next values
  always_comb begin
    cnt_next        = '0;
    rc_next         = rc;
    buf_valid_next  = buf_valid;
    clear_addr_next = clear_addr;
    case (state)
      mcbr_pkg::ST_CLEAR: clear_addr_next = clear_addr + STORE_AW'(1);
      mcbr_pkg::ST_IDLE: begin
        if (go) begin
          case (cmd.op)
            mcbr_pkg::OP_START: begin
              rc_next        = '0;
              buf_valid_next = '0;
            end
            mcbr_pkg::OP_WR_BYTE: begin
              rc_next                   = (cmd.seed ? cmd.seed_value : rc) ^ cmd.data;
              buf_valid_next[cmd.index] = 1'b1;
            end
            mcbr_pkg::OP_RD_LOAD: begin
              if (!cmd.sector_valid) begin
                rc_next        = cmd.seed_value;
                buf_valid_next = '0;
              end
            end
            default: rc_next = rc;
          endcase
        end
      end
      mcbr_pkg::ST_RD_WAIT: rc_next = rc ^ rd_byte;
      mcbr_pkg::ST_LOAD: begin
        cnt_next = cnt + CNT_W'(1);
        if (sweep_done) begin
          rc_next        = cmd.seed_value ^ first_byte;
          buf_valid_next = '1;
        end
      end
      mcbr_pkg::ST_COMMIT: cnt_next = cnt + CNT_W'(1);
      default: cnt_next = '0;
    endcase
  end

  // memory controls and handshakes
  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res.data  = mcbr_pkg::RSP_NONE;
    res.ack   = 1'b1;
    buf_we    = 1'b0;
    buf_waddr = cmd.index;
    buf_wdata = cmd.data;
    buf_raddr = cmd.index;
    st_we     = 1'b0;
    st_waddr  = {cmd.sector[SECT_W-1:0], cnt_prev};
    st_wdata  = vld_q ? buf_rdata : 8'h00;
    st_raddr  = {cmd.sector[SECT_W-1:0], cnt[BUF_AW-1:0]};
    case (state)
      mcbr_pkg::ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clear_addr;
        st_wdata = 8'h00;
      end
      mcbr_pkg::ST_IDLE: begin
        if (go) begin
          case (cmd.op)
            mcbr_pkg::OP_IMM, mcbr_pkg::OP_START: begin
              cmd_pop  = 1'b1;
              res_push = 1'b1;
              res.data = cmd.data;
              res.ack  = cmd.ack;
            end
            mcbr_pkg::OP_WR_BYTE: begin
              cmd_pop  = 1'b1;
              res_push = 1'b1;
              buf_we   = 1'b1;
            end
            mcbr_pkg::OP_RD_CHECK: begin
              cmd_pop  = 1'b1;
              res_push = 1'b1;
              res.data = rc;
            end
            mcbr_pkg::OP_RD_LOAD: begin
              if (!cmd.sector_valid) begin
                cmd_pop  = 1'b1;
                res_push = 1'b1;
              end
            end
            mcbr_pkg::OP_COMMIT: begin
              res.ack = 1'b0;
              if (!cmd.sector_valid) begin
                cmd_pop  = 1'b1;
                res_push = 1'b1;
                res.data = mcbr_pkg::RSP_BAD;
              end else if (!check_ok) begin
                cmd_pop  = 1'b1;
                res_push = 1'b1;
                res.data = mcbr_pkg::RSP_BAD_CHECK;
              end
            end
            default: cmd_pop = 1'b0;
          endcase
        end
      end
      mcbr_pkg::ST_RD_WAIT: begin
        cmd_pop  = 1'b1;
        res_push = 1'b1;
        res.data = rd_byte;
      end
      mcbr_pkg::ST_LOAD: begin
        buf_we    = (cnt != '0);
        buf_waddr = cnt_prev;
        buf_wdata = st_rdata;
        if (sweep_done) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          res.data = first_byte;
        end
      end
      mcbr_pkg::ST_COMMIT: begin
        buf_raddr = cnt[BUF_AW-1:0];
        st_we     = (cnt != '0);
        if (sweep_done) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          res.data = mcbr_pkg::RSP_GOOD;
          res.ack  = 1'b0;
        end
      end
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mcbr_pkg::ST_CLEAR;
      cnt        <= '0;
      rc         <= '0;
      buf_valid  <= '0;
      clear_addr <= '0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      rc         <= rc_next;
      buf_valid  <= buf_valid_next;
      clear_addr <= clear_addr_next;
    end
  end

  // first byte of a sector load, kept for the answer at the end of the sweep
  always_ff @(posedge clk) begin
    vld_q <= buf_valid[buf_raddr];
    if (state == mcbr_pkg::ST_LOAD && cnt == CNT_W'(1)) begin
      first_byte <= st_rdata;
    end
  end

  mcbr_ram #(
    .WIDTH(8),
    .DEPTH(mcbr_pkg::SECTOR_BYTES)
  ) u_sector_buf (
    .clk  (clk),
    .we   (buf_we),
    .waddr(buf_waddr),
    .wdata(buf_wdata),
    .raddr(buf_raddr),
    .rdata(buf_rdata)
  );

  mcbr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_card_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

endmodule

### src/ps1_memory_card_byte_responder.sv
// ps1_memory_card_byte_responder: card side of the byte-serial sector exchange
// depends on mcbr_pkg, mcbr_fifo, mcbr_front and mcbr_back
//
//   channel   handshake            payload
//   ------    ---------            -------
//   input     push / full          req_type[1:0], data_in[7:0]
//   result    pop / empty          data_out[7:0], ack
//   config    cfg_valid/cfg_ready  cfg_data (card_present)
//
// work: header, command and write-data bytes are answered by the back end from idle, a
//   buffered read byte by way of the read-wait state; a good-sector read load and an
//   accepted commit run a byte-wide sweep between sector buffer and card store; a result
//   reaches the ports through the registered work queue and result queue
// reset: store zeroed one byte a cycle, full held high until the clearing pass ends
// stalls: two-entry work queue before the back end, two-entry result queue after it

module ps1_memory_card_byte_responder #(
  parameter int SECTOR_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type,
  input  logic [7:0] data_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_out,
  output logic       ack,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  // front end to work queue
  logic           cmd_push;
  mcbr_pkg::cmd_t cmd_in;
  logic           cmdq_full;

  // work queue to back end
  mcbr_pkg::cmd_t cmd_head;
  logic           cmdq_empty;
  logic           cmd_pop;

  // back end to result queue
  logic              res_push;
  mcbr_pkg::result_t res_in;
  logic              res_full;
  mcbr_pkg::result_t res_head;

  // store clearing pass in progress
  logic clearing;

  mcbr_front #(
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req_type (req_type),
    .data_in  (data_in),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .cmdq_full(cmdq_full),
    .clearing (clearing),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // classified work waits here for the back end
  mcbr_fifo #(
    .WIDTH($bits(mcbr_pkg::cmd_t)),
    .DEPTH(mcbr_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmdq_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmdq_empty)
  );

  mcbr_back #(
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_head),
    .cmd_valid(!cmdq_empty),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in),
    .clearing (clearing)
  );

  // finished response bytes wait here for the host
  mcbr_fifo #(
    .WIDTH($bits(mcbr_pkg::result_t)),
    .DEPTH(mcbr_pkg::RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_head),
    .empty(empty)
  );

  assign data_out = res_head.data;
  assign ack      = res_head.ack;

endmodule

### test/tb_ps1_memory_card_byte_responder.sv
`timescale 1ns / 100ps
// tb_ps1_memory_card_byte_responder: self-checking bench for the memory card byte responder
// depends on mcbr_pkg and the ps1_memory_card_byte_responder rtl; predicts every answer
// byte in a small tracker class and checks the result queue in order

module tb_ps1_memory_card_byte_responder;

  localparam int SECTOR_COUNT = 1024;
  localparam int STORE_BYTES  = SECTOR_COUNT * mcbr_pkg::SECTOR_BYTES;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // slots of the ring of answers still owed, far above what the queues can hold
  localparam int DUE_SLOTS    = 64;
  // request code with no meaning, the block answers it with 0x00, ack low, and keeps its position
  localparam logic [1:0] REQ_NONE = 2'd3;
  // byte positions used by the stimulus tasks
  localparam int P_FIRST   = int'(mcbr_pkg::POS_FIRST);
  localparam int P_SECT_HI = int'(mcbr_pkg::POS_SECT_HI);
  localparam int P_SECT_LO = int'(mcbr_pkg::POS_SECT_LO);
  localparam int P_WR_DATA = int'(mcbr_pkg::POS_WR_DATA);
  localparam int P_WR_CHK  = int'(mcbr_pkg::POS_WR_CHK);
  // full transaction lengths after the start byte, positions 2 up to the last one
  localparam int WR_SPAN = int'(mcbr_pkg::POS_WR_LAST) - P_FIRST + 1;
  localparam int RD_SPAN = int'(mcbr_pkg::POS_RD_LAST) - P_FIRST + 1;

  // card-side state mirror and the ring of answers still owed by the block
  class card_answer_tracker;
    logic              present;
    logic [7:0]        position;
    logic [7:0]        sect_hi;
    logic [7:0]        sect_lo;
    logic [7:0]        run_chk;
    logic [7:0]        host_chk;
    logic              sect_ok;
    logic [7:0]        sector_buf [mcbr_pkg::SECTOR_BYTES];
    logic [7:0]        store [STORE_BYTES];
    mcbr_pkg::result_t answers_due [DUE_SLOTS];
    int                due_head;
    int                due_tail;
    int                mismatches;
    int                answers_checked;
    int                bytes_taken;
    int                commits_taken;

    function new();
      present = 1'b1;
      position = mcbr_pkg::POS_FIRST;
      sect_hi = 8'h00;
      sect_lo = 8'h00;
      run_chk = 8'h00;
      host_chk = 8'h00;
      sect_ok = 1'b0;
      foreach (sector_buf[k]) sector_buf[k] = 8'h00;
      foreach (store[k]) store[k] = 8'h00;
      due_head = 0;
      due_tail = 0;
      mismatches = 0;
      answers_checked = 0;
      bytes_taken = 0;
      commits_taken = 0;
    endfunction

    // number of answers noted and not yet checked
    function int answers_owed();
      return due_tail - due_head;
    endfunction

    // work out the answer to one accepted host byte and queue it
    function void note_host_byte(logic [1:0] rq, logic [7:0] d);
      mcbr_pkg::result_t ans;
      logic [7:0]        pos;
      logic [6:0]        idx;
      int                base;
      pos = position;
      ans.data = mcbr_pkg::RSP_NONE;
      ans.ack = 1'b0;
      bytes_taken++;
      case (rq)
        mcbr_pkg::REQ_START: begin
          position = mcbr_pkg::POS_FIRST;
          sect_hi = 8'h00;
          sect_lo = 8'h00;
          run_chk = 8'h00;
          host_chk = 8'h00;
          foreach (sector_buf[k]) sector_buf[k] = 8'h00;
          ans.data = mcbr_pkg::RSP_BAD;
          ans.ack = present;
        end
        mcbr_pkg::REQ_READ: begin
          if (!present) begin
            ans.data = mcbr_pkg::RSP_BAD;
          end else if (pos >= mcbr_pkg::POS_FIRST && pos <= mcbr_pkg::POS_RD_LAST) begin
            ans.ack = 1'b1;
            case (pos)
              mcbr_pkg::POS_FIRST:   ans.data = mcbr_pkg::RSP_ID1;
              mcbr_pkg::POS_ID2:     ans.data = mcbr_pkg::RSP_ID2;
              mcbr_pkg::POS_SECT_HI: sect_hi = d;
              mcbr_pkg::POS_SECT_LO: begin
                sect_lo = d;
                sect_ok = {sect_hi, sect_lo} < SECTOR_COUNT;
              end
              mcbr_pkg::POS_RD_ACK1: ans.data = mcbr_pkg::RSP_ACK1;
              mcbr_pkg::POS_RD_ACK2: ans.data = mcbr_pkg::RSP_ID2;
              mcbr_pkg::POS_RD_HI:   ans.data = sect_hi;
              mcbr_pkg::POS_RD_LO:   ans.data = sect_lo;
              mcbr_pkg::POS_RD_CHK:  ans.data = run_chk;
              mcbr_pkg::POS_RD_LAST: begin
                ans.data = mcbr_pkg::RSP_GOOD;
                ans.ack = 1'b0;
              end
              default: begin
                idx = 7'(pos - mcbr_pkg::POS_RD_DATA);
                // first data byte loads the sector, a bad sector reads as zeros
                if (pos == mcbr_pkg::POS_RD_DATA) begin
                  run_chk = sect_hi ^ sect_lo;
                  base = int'({sect_hi, sect_lo}) * mcbr_pkg::SECTOR_BYTES;
                  foreach (sector_buf[k])
                    sector_buf[k] = sect_ok ? store[(base + k) % STORE_BYTES] : 8'h00;
                end
                ans.data = sector_buf[idx];
                run_chk ^= ans.data;
              end
            endcase
            position = pos + 8'd1;
          end
        end
        mcbr_pkg::REQ_WRITE: begin
          if (pos >= mcbr_pkg::POS_FIRST && pos <= mcbr_pkg::POS_WR_LAST) begin
            ans.ack = 1'b1;
            case (pos)
              mcbr_pkg::POS_FIRST:   ans.data = mcbr_pkg::RSP_ID1;
              mcbr_pkg::POS_ID2:     ans.data = mcbr_pkg::RSP_ID2;
              mcbr_pkg::POS_SECT_HI: sect_hi = d;
              mcbr_pkg::POS_SECT_LO: begin
                sect_lo = d;
                sect_ok = {sect_hi, sect_lo} < SECTOR_COUNT;
              end
              mcbr_pkg::POS_WR_CHK:  host_chk = d;
              mcbr_pkg::POS_WR_ACK1: ans.data = mcbr_pkg::RSP_ACK1;
              mcbr_pkg::POS_WR_ACK2: ans.data = mcbr_pkg::RSP_ID2;
              mcbr_pkg::POS_WR_LAST: begin
                ans.ack = 1'b0;
                if (!sect_ok) begin
                  ans.data = mcbr_pkg::RSP_BAD;
                end else if (host_chk != run_chk) begin
                  ans.data = mcbr_pkg::RSP_BAD_CHECK;
                end else begin
                  base = int'({sect_hi, sect_lo}) * mcbr_pkg::SECTOR_BYTES;
                  foreach (sector_buf[k]) store[(base + k) % STORE_BYTES] = sector_buf[k];
                  ans.data = mcbr_pkg::RSP_GOOD;
                  commits_taken++;
                end
              end
              default: begin
                idx = 7'(pos - mcbr_pkg::POS_WR_DATA);
                if (pos == mcbr_pkg::POS_WR_DATA) run_chk = sect_hi ^ sect_lo;
                sector_buf[idx] = d;
                run_chk ^= d;
              end
            endcase
            position = pos + 8'd1;
          end
        end
        default: ;
      endcase
      answers_due[due_tail % DUE_SLOTS] = ans;
      due_tail++;
    endfunction

    // compare one popped answer with the oldest one owed
    function void check_card_answer(logic [7:0] d, logic a);
      mcbr_pkg::result_t due;
      if (answers_owed() == 0) begin
        $error("answer data_out 0x%02h ack %0b with no host byte waiting", d, a);
        mismatches++;
        return;
      end
      due = answers_due[due_head % DUE_SLOTS];
      due_head++;
      answers_checked++;
      if (d !== due.data) begin
        $error("data_out: expected 0x%02h, actual 0x%02h", due.data, d);
        mismatches++;
      end
      if (a !== due.ack) begin
        $error("ack: expected %0b, actual %0b", due.ack, a);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] req_type = mcbr_pkg::REQ_START;
  logic [7:0] data_in = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] data_out;
  logic       ack;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  card_answer_tracker tracker;

  // idle odds in percent for each side, sender busy and receiver stalled first
  int send_idle = 28;
  int recv_idle = 83;
  // cycles the result side still holds pop low, counted down by the receiver
  int pop_hold_left = 0;
  int cycles = 0;

  ps1_memory_card_byte_responder #(
    .SECTOR_COUNT(SECTOR_COUNT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req_type (req_type),
    .data_in  (data_in),
    .empty    (empty),
    .pop      (pop),
    .data_out (data_out),
    .ack      (ack),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hang guard, the reset clearing pass of the store is well inside it
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check on every pop transaction, then pick the next pop level
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) tracker.check_card_answer(data_out, ack);
      if (rst) begin
        pop <= 1'b0;
      end else if (pop_hold_left > 0) begin
        // long hold-off so the block backs up and raises full
        pop_hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // offer one host byte and wait for its push transaction
  // push stays high into the next byte when no gap is drawn
  task automatic send_byte(input logic [1:0] rq, input logic [7:0] d);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rq;
    data_in <= d;
    do @(posedge clk); while (full);
    tracker.note_host_byte(rq, d);
  endtask

  // sender pause until every owed answer has been popped
  task automatic wait_for_answers();
    push <= 1'b0;
    while (tracker.answers_owed() != 0) @(posedge clk);
  endtask

  // card_present register write, only issued with the block drained
  task automatic set_card_present(input logic present);
    cfg_valid <= 1'b1;
    cfg_data <= present;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.present = present;
  endtask

  // start plus span write bytes; the host check is right or deliberately off
  task automatic write_sector(input logic [15:0] sect, input bit check_ok, input int span);
    logic [7:0] chk;
    logic [7:0] b;
    int         pos;
    chk = sect[15:8] ^ sect[7:0];
    send_byte(mcbr_pkg::REQ_START, 8'($urandom_range(255)));
    for (pos = P_FIRST; pos < P_FIRST + span; pos++) begin
      b = 8'($urandom_range(255));
      if (pos == P_SECT_HI) b = sect[15:8];
      else if (pos == P_SECT_LO) b = sect[7:0];
      else if (pos >= P_WR_DATA && pos < P_WR_CHK) chk ^= b;
      else if (pos == P_WR_CHK) b = check_ok ? chk : chk ^ 8'($urandom_range(1, 255));
      send_byte(mcbr_pkg::REQ_WRITE, b);
    end
  endtask

  // start plus span read bytes with random filler outside the sector number
  task automatic read_sector(input logic [15:0] sect, input int span);
    logic [7:0] b;
    int         pos;
    send_byte(mcbr_pkg::REQ_START, 8'($urandom_range(255)));
    for (pos = P_FIRST; pos < P_FIRST + span; pos++) begin
      b = 8'($urandom_range(255));
      if (pos == P_SECT_HI) b = sect[15:8];
      else if (pos == P_SECT_LO) b = sect[7:0];
      send_byte(mcbr_pkg::REQ_READ, b);
    end
  endtask

  // any request code, the meaningless one included
  task automatic noise_burst(input int n);
    repeat (n) send_byte(2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  initial begin
    logic [15:0] sect;
    int          k;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // taken even while the store is still being cleared
    set_card_present(1'b1);

    // directed: read header of a sector just past the end, reads back as zeros
    send_byte(mcbr_pkg::REQ_START, 8'h00);
    send_byte(mcbr_pkg::REQ_READ, 8'hFF);
    send_byte(mcbr_pkg::REQ_READ, 8'h00);
    send_byte(mcbr_pkg::REQ_READ, 8'h04);
    send_byte(mcbr_pkg::REQ_READ, 8'h00);
    for (k = 0; k < 7; k++) send_byte(mcbr_pkg::REQ_READ, k[0] ? 8'hFF : 8'h00);
    send_byte(REQ_NONE, 8'hFF);
    // directed: write header to the last good sector, then one data byte
    send_byte(mcbr_pkg::REQ_START, 8'hFF);
    send_byte(mcbr_pkg::REQ_WRITE, 8'h00);
    send_byte(mcbr_pkg::REQ_WRITE, 8'hFF);
    send_byte(mcbr_pkg::REQ_WRITE, 8'h03);
    send_byte(mcbr_pkg::REQ_WRITE, 8'hFF);
    send_byte(mcbr_pkg::REQ_WRITE, 8'hFF);
    send_byte(REQ_NONE, 8'h00);
    wait_for_answers();

    // card pulled: start acks low, reads answer 0xFF, writes carry on
    set_card_present(1'b0);
    send_byte(mcbr_pkg::REQ_START, 8'h5A);
    send_byte(mcbr_pkg::REQ_READ, 8'hA5);
    send_byte(mcbr_pkg::REQ_WRITE, 8'h3C);
    send_byte(REQ_NONE, 8'hC3);
    wait_for_answers();
    set_card_present(1'b1);

    // sender busy, receiver mostly stalled: good write of a sector
    send_idle = 28;
    recv_idle = 83;
    case ($urandom_range(2))
      0:       sect = 16'd0;
      1:       sect = 16'(SECTOR_COUNT - 1);
      default: sect = 16'($urandom_range(1, SECTOR_COUNT - 2));
    endcase
    write_sector(sect, 1'b1, WR_SPAN);
    noise_burst($urandom_range(3, 8));
    wait_for_answers();

    // the other way round: read it back and run past the end, then a cut-off read
    send_idle = 83;
    recv_idle = 28;
    read_sector(sect, RD_SPAN + 3);
    read_sector(16'($urandom_range(SECTOR_COUNT - 1)), $urandom_range(3, 15));
    noise_burst($urandom_range(3, 8));
    wait_for_answers();

    // no idling, with one long pop hold-off up front so input backs up
    send_idle = 0;
    recv_idle = 0;
    pop_hold_left = 250;
    write_sector(sect, 1'b0, WR_SPAN);
    write_sector(16'($urandom_range(SECTOR_COUNT, 65535)), 1'b1, WR_SPAN + 2);
    noise_burst($urandom_range(5, 12));
    wait_for_answers();

    // trailing cycles for anything the block might still send
    repeat (20) @(posedge clk);
    $display("covered %0d host bytes, %0d answers checked, %0d sector commits accepted",
             tracker.bytes_taken, tracker.answers_checked, tracker.commits_taken);
    $display("with card present and absent, good and bad sectors, check mismatch, overrun");
    if (tracker.mismatches == 0 && tracker.answers_owed() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
